[rtl/core/abs_pkg.sv]
// Shared widths, codes and constants of the ADC block average scaler.
package abs_pkg;

  localparam int SMP_W     = 12;
  localparam int SUM_W     = 19;
  localparam int LEFT_W    = 8;
  localparam int VFS_W     = 16;
  localparam int OFF_W     = 8;
  localparam int CFS_W     = 12;
  localparam int RES_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Shared serial units.
  localparam int DIV_DVD_W = 28;
  localparam int DIV_DVS_W = 16;
  localparam int MUL_A_W   = 20;
  localparam int MUL_B_W   = 16;

  localparam int AVG_COUNT_DEF = 128;
  localparam int ADC_BITS_DEF  = 12;

  // Divisor that turns millivolts with 8 fractional bits into offset counts.
  localparam logic [DIV_DVS_W-1:0] MV_PER_COUNT_Q = 16'd625;

  localparam logic [VFS_W-1:0] VFS_RESET = 16'd30000;
  localparam logic [OFF_W-1:0] OFF_RESET = 8'd6;
  localparam logic [CFS_W-1:0] CFS_RESET = 12'd999;

  localparam logic [CFG_IDX_W-1:0] REG_VOLT_FS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_OFF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_FS   = 2'd2;

  localparam logic [1:0] FUNC_LIST0 = 2'd0;
  localparam logic [1:0] FUNC_LIST1 = 2'd1;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_BUF  = 2'd1;
  localparam logic [1:0] ERR_SRC  = 2'd2;

endpackage

[rtl/core/abs_if.sv]
// Valid/ready channel interfaces for ADC events and published results.
interface abs_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic                      buffer_ok;
  logic [abs_pkg::SMP_W-1:0] current_sample;
  logic [abs_pkg::SMP_W-1:0] voltage_sample;
  logic                      cv_pin;

  modport source (output valid, func, buffer_ok, current_sample, voltage_sample, cv_pin,
                  input ready);
  modport sink   (input valid, func, buffer_ok, current_sample, voltage_sample, cv_pin,
                  output ready);
endinterface

interface abs_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                error_code;
  logic                      cv_mode;
  logic                      result_new;
  logic [abs_pkg::SMP_W-1:0] avg_voltage_counts;
  logic [abs_pkg::SMP_W-1:0] avg_current_counts;
  logic [abs_pkg::RES_W-1:0] voltage_mv;
  logic [abs_pkg::RES_W-1:0] current_tenth_ma;

  modport source (output valid, error_code, cv_mode, result_new, avg_voltage_counts,
                  avg_current_counts, voltage_mv, current_tenth_ma,
                  input ready);
  modport sink   (input valid, error_code, cv_mode, result_new, avg_voltage_counts,
                  avg_current_counts, voltage_mv, current_tenth_ma,
                  output ready);
endinterface

[rtl/core/abs_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module abs_div #(
  parameter int DVD_W = abs_pkg::DIV_DVD_W,
  parameter int DVS_W = abs_pkg::DIV_DVS_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   trial_sub;

  // The dividend shifts out at the top while quotient bits shift in below.
  always_comb begin
    trial     = {rem_r, dvd_r[DVD_W-1]};
    trial_sub = trial - {1'b0, dvs_r};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = trial_sub[DVS_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DVS_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(DVD_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = dvd_r;
  assign done     = done_r;

endmodule

[rtl/core/abs_mul.sv]
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module abs_mul #(
  parameter int A_W = abs_pkg::MUL_A_W,
  parameter int B_W = abs_pkg::MUL_B_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [A_W-1:0]   mcand,
  input  logic [B_W-1:0]   mplier,
  output logic [A_W+B_W-1:0] product,
  output logic             done
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [CNT_W-1:0]   cnt_r;
  logic               done_r;
  logic [A_W-1:0]     a_r;
  logic [A_W+B_W-1:0] p_r;
  logic [A_W:0]       part;

  // The upper half accumulates while the multiplier drains out at the bottom.
  assign part = {1'b0, p_r[A_W+B_W-1:B_W]} + (p_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(B_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= mcand;
      p_r <= {{A_W{1'b0}}, mplier};
    end else if (cnt_r != '0) begin
      p_r <= {part, p_r[B_W-1:1]};
    end
  end

  assign product = p_r;
  assign done    = done_r;

endmodule

[rtl/core/adc_block_average_scaler.sv]
// Top level of the ADC block average scaler: event handling, sequencer and result register.
// An event that does not publish is accepted in S_IDLE, and S_OUT loads its result into the
// result register once it is empty or draining; the next event is then accepted in S_IDLE.
// A publishing event runs the serial datapath: five 28-step divisions and two 16-step
// multiplications, or four and one when the current clamps at zero, before S_OUT.
// Synchronous active-low reset restores the register defaults, clears sums, countdown,
// held results and error state, and empties the result register.
module adc_block_average_scaler #(
  parameter int AVG_COUNT = abs_pkg::AVG_COUNT_DEF,
  parameter int ADC_BITS  = abs_pkg::ADC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  abs_in_if.sink                        in_ch,
  abs_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [abs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [abs_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam int SMP_W  = abs_pkg::SMP_W;
  localparam int SUM_W  = abs_pkg::SUM_W;
  localparam int LEFT_W = abs_pkg::LEFT_W;
  localparam int RES_W  = abs_pkg::RES_W;
  localparam int DVD_W  = abs_pkg::DIV_DVD_W;
  localparam int DVS_W  = abs_pkg::DIV_DVS_W;
  localparam int A_W    = abs_pkg::MUL_A_W;
  localparam int B_W    = abs_pkg::MUL_B_W;

  // Full-scale code of the converter and the block length as divisors.
  localparam logic [DVS_W-1:0]  FULL_SCALE = DVS_W'((1 << ADC_BITS) - 1);
  localparam logic [DVS_W-1:0]  AVG_DVS    = DVS_W'(AVG_COUNT);
  localparam logic [LEFT_W-1:0] AVG_LOAD   = LEFT_W'(AVG_COUNT);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_C,     // sum of current samples / block length
    S_DIV_V,     // sum of voltage samples / block length
    S_MUL_V,     // average voltage * voltage full scale
    S_DIV_MV,    // ... / converter full scale gives millivolts
    S_DIV_OFF,   // millivolts * 256 / 625 gives the voltage-dependent offset
    S_MUL_C,     // corrected current * current full scale * 10
    S_DIV_CUR,   // ... / (converter full scale * 256) gives tenths of mA
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   launch_r, launch_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic [abs_pkg::VFS_W-1:0] vfs_r, vfs_nxt;
  logic [abs_pkg::OFF_W-1:0] off_r, off_nxt;
  logic [abs_pkg::CFS_W-1:0] cfs_r, cfs_nxt;

  logic [SUM_W-1:0]  sum_c_r, sum_c_nxt;
  logic [SUM_W-1:0]  sum_v_r, sum_v_nxt;
  logic [LEFT_W-1:0] left_r, left_nxt;
  logic [1:0]        err_r, err_nxt;
  logic              mode_r, mode_nxt;
  logic              fresh_r, fresh_nxt;
  logic [SMP_W-1:0]  havg_v_r, havg_v_nxt;
  logic [SMP_W-1:0]  havg_c_r, havg_c_nxt;
  logic [RES_W-1:0]  hmv_r, hmv_nxt;
  logic [RES_W-1:0]  hcur_r, hcur_nxt;
  logic [A_W-1:0]    diff_r, diff_nxt;

  logic [1:0]        o_err_r;
  logic              o_mode_r;
  logic              o_fresh_r;
  logic [SMP_W-1:0]  o_avg_v_r;
  logic [SMP_W-1:0]  o_avg_c_r;
  logic [RES_W-1:0]  o_mv_r;
  logic [RES_W-1:0]  o_cur_r;
  logic              out_load;

  logic             in_xfer;
  logic             div_start, div_done;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs;
  logic             mul_start, mul_done;
  logic [A_W-1:0]   mul_a;
  logic [B_W-1:0]   mul_b;
  logic [A_W+B_W-1:0] mul_p;
  logic [RES_W-1:0] div_q_sat;
  logic [16:0]      off_q8;
  logic [A_W-1:0]   cur_q8;
  logic [B_W-1:0]   cfs_x10;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Operand selection for the shared divider and multiplier follows the sequencer state.
  always_comb begin
    case (state_r)
      S_DIV_C:   begin div_dvd = DVD_W'(sum_c_r);       div_dvs = AVG_DVS;        end
      S_DIV_V:   begin div_dvd = DVD_W'(sum_v_r);       div_dvs = AVG_DVS;        end
      S_DIV_MV:  begin div_dvd = mul_p[DVD_W-1:0];      div_dvs = FULL_SCALE;     end
      S_DIV_OFF: begin div_dvd = DVD_W'({hmv_r, 8'h00}); div_dvs = abs_pkg::MV_PER_COUNT_Q; end
      S_DIV_CUR: begin div_dvd = mul_p[A_W+B_W-1:8];    div_dvs = FULL_SCALE;     end
      default:   begin div_dvd = DVD_W'(sum_c_r);       div_dvs = AVG_DVS;        end
    endcase
  end

  // Ten times the current full scale, built from two shifts.
  assign cfs_x10 = B_W'({cfs_r, 3'b000}) + B_W'({cfs_r, 1'b0});

  always_comb begin
    if (state_r == S_MUL_C) begin
      mul_a = diff_r;
      mul_b = cfs_x10;
    end else begin
      mul_a = A_W'(havg_v_r);
      mul_b = vfs_r;
    end
  end

  assign div_start = launch_r && (state_r == S_DIV_C || state_r == S_DIV_V ||
                                  state_r == S_DIV_MV || state_r == S_DIV_OFF ||
                                  state_r == S_DIV_CUR);
  assign mul_start = launch_r && (state_r == S_MUL_V || state_r == S_MUL_C);

  // Scaled results saturate at the top of the 16-bit range.
  assign div_q_sat = (div_q[DVD_W-1:RES_W] != '0) ? {RES_W{1'b1}} : div_q[RES_W-1:0];

  // The offset keeps 8 fractional bits: fixed counts plus the voltage-dependent part.
  assign off_q8 = {1'b0, off_r, 8'h00} + {2'b00, div_q[14:0]};
  assign cur_q8 = {havg_c_r, 8'h00};

  abs_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  abs_mul #(
    .A_W (A_W),
    .B_W (B_W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .product (mul_p),
    .done    (mul_done)
  );

  always_comb begin
    state_nxt     = state_r;
    launch_nxt    = 1'b0;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    vfs_nxt       = vfs_r;
    off_nxt       = off_r;
    cfs_nxt       = cfs_r;
    sum_c_nxt     = sum_c_r;
    sum_v_nxt     = sum_v_r;
    left_nxt      = left_r;
    err_nxt       = err_r;
    mode_nxt      = mode_r;
    fresh_nxt     = fresh_r;
    havg_v_nxt    = havg_v_r;
    havg_c_nxt    = havg_c_r;
    hmv_nxt       = hmv_r;
    hcur_nxt      = hcur_r;
    diff_nxt      = diff_r;

    // Configuration writes land at any time; an index past the list is ignored.
    if (cfg_we) begin
      case (cfg_index)
        abs_pkg::REG_VOLT_FS: vfs_nxt = cfg_data;
        abs_pkg::REG_CUR_OFF: off_nxt = cfg_data[abs_pkg::OFF_W-1:0];
        abs_pkg::REG_CUR_FS:  cfs_nxt = cfg_data[abs_pkg::CFS_W-1:0];
        default: ;
      endcase
    end

    // The result register drains on an output transfer.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          mode_nxt  = !in_ch.cv_pin;
          fresh_nxt = 1'b0;
          state_nxt = S_OUT;
          case (in_ch.func)
            abs_pkg::FUNC_LIST0: begin
              if (in_ch.buffer_ok) begin
                err_nxt = abs_pkg::ERR_NONE;
                if (left_r != '0) begin
                  left_nxt  = left_r - LEFT_W'(1);
                  sum_c_nxt = sum_c_r + SUM_W'(in_ch.current_sample);
                  sum_v_nxt = sum_v_r + SUM_W'(in_ch.voltage_sample);
                end else begin
                  // Countdown expired: this event's samples are dropped and the
                  // block is published.
                  left_nxt   = AVG_LOAD;
                  fresh_nxt  = 1'b1;
                  state_nxt  = S_DIV_C;
                  launch_nxt = 1'b1;
                end
              end else begin
                err_nxt = abs_pkg::ERR_BUF;
              end
            end
            abs_pkg::FUNC_LIST1: ;
            default: err_nxt = abs_pkg::ERR_SRC;
          endcase
        end
      end
      S_DIV_C: begin
        if (div_done && !launch_r) begin
          havg_c_nxt = div_q[SMP_W-1:0];
          sum_c_nxt  = '0;
          state_nxt  = S_DIV_V;
          launch_nxt = 1'b1;
        end
      end
      S_DIV_V: begin
        if (div_done && !launch_r) begin
          havg_v_nxt = div_q[SMP_W-1:0];
          sum_v_nxt  = '0;
          state_nxt  = S_MUL_V;
          launch_nxt = 1'b1;
        end
      end
      S_MUL_V: begin
        if (mul_done && !launch_r) begin
          state_nxt  = S_DIV_MV;
          launch_nxt = 1'b1;
        end
      end
      S_DIV_MV: begin
        if (div_done && !launch_r) begin
          hmv_nxt    = div_q_sat;
          state_nxt  = S_DIV_OFF;
          launch_nxt = 1'b1;
        end
      end
      S_DIV_OFF: begin
        if (div_done && !launch_r) begin
          if (cur_q8 > A_W'(off_q8)) begin
            diff_nxt   = cur_q8 - A_W'(off_q8);
            state_nxt  = S_MUL_C;
            launch_nxt = 1'b1;
          end else begin
            // The offset covers the whole reading: current clamps at zero.
            hcur_nxt  = '0;
            state_nxt = S_OUT;
          end
        end
      end
      S_MUL_C: begin
        if (mul_done && !launch_r) begin
          state_nxt  = S_DIV_CUR;
          launch_nxt = 1'b1;
        end
      end
      S_DIV_CUR: begin
        if (div_done && !launch_r) begin
          hcur_nxt  = div_q_sat;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
      vfs_r       <= abs_pkg::VFS_RESET;
      off_r       <= abs_pkg::OFF_RESET;
      cfs_r       <= abs_pkg::CFS_RESET;
      sum_c_r     <= '0;
      sum_v_r     <= '0;
      left_r      <= '0;
      err_r       <= abs_pkg::ERR_NONE;
      mode_r      <= 1'b0;
      fresh_r     <= 1'b0;
      havg_v_r    <= '0;
      havg_c_r    <= '0;
      hmv_r       <= '0;
      hcur_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
      vfs_r       <= vfs_nxt;
      off_r       <= off_nxt;
      cfs_r       <= cfs_nxt;
      sum_c_r     <= sum_c_nxt;
      sum_v_r     <= sum_v_nxt;
      left_r      <= left_nxt;
      err_r       <= err_nxt;
      mode_r      <= mode_nxt;
      fresh_r     <= fresh_nxt;
      havg_v_r    <= havg_v_nxt;
      havg_c_r    <= havg_c_nxt;
      hmv_r       <= hmv_nxt;
      hcur_r      <= hcur_nxt;
    end
  end

  // Datapath and result payload registers carry no reset.
  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    if (out_load) begin
      o_err_r   <= err_r;
      o_mode_r  <= mode_r;
      o_fresh_r <= fresh_r;
      o_avg_v_r <= havg_v_r;
      o_avg_c_r <= havg_c_r;
      o_mv_r    <= hmv_r;
      o_cur_r   <= hcur_r;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.error_code         = o_err_r;
  assign out_ch.cv_mode            = o_mode_r;
  assign out_ch.result_new         = o_fresh_r;
  assign out_ch.avg_voltage_counts = o_avg_v_r;
  assign out_ch.avg_current_counts = o_avg_c_r;
  assign out_ch.voltage_mv         = o_mv_r;
  assign out_ch.current_tenth_ma   = o_cur_r;

endmodule

[rtl/core/abs_chk.sv]
// Port-level checker for the ADC block average scaler and its bind.
module abs_chk (
  input logic         clk,
  input logic         rst_n,
  abs_out_if.source   out_ch
);

  // A waiting result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result withdrawn before transfer");

  // A publishing event is always a good list-0 event.
  a_new_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.result_new |-> out_ch.error_code == abs_pkg::ERR_NONE)
    else $error("new average reported together with an error");

  // A nonzero current needs a nonzero averaged current reading.
  a_cur_needs_avg: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.current_tenth_ma != '0 |-> out_ch.avg_current_counts != '0)
    else $error("current reported from a zero average");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result offered right after reset");

endmodule

bind adc_block_average_scaler abs_chk u_abs_chk (
  .clk    (clk),
  .rst_n  (rst_n),
  .out_ch (out_ch)
);

[bench/adc_block_average_scaler_test.sv]
// Self-checking testbench of the ADC block average scaler with a built-in predictor.
module adc_block_average_scaler_test;
  import abs_pkg::*;

  // Interrupt sources that the package leaves unnamed. Both are treated as unknown.
  localparam logic [1:0] FUNC_UNKNOWN = 2'd2;
  localparam logic [1:0] FUNC_SPARE   = 2'd3;

  localparam longint unsigned FULL_SCALE = (64'd1 << ADC_BITS_DEF) - 1;
  localparam longint unsigned SMP_MASK   = (64'd1 << SMP_W) - 1;

  // The receiver holds off this long once, which is well past the point where
  // the block has filled its result register and stopped taking events.
  localparam int unsigned RESULT_HOLD_CYCLES = 320;
  // A publishing event and a stall on either side are both shorter, and
  // the long hold-off above is the longest quiet stretch of a correct run.
  localparam int unsigned QUIET_LIMIT        = 4000;
  localparam int unsigned SETTLE_CYCLES      = 200;
  localparam int unsigned PHASE_ITEMS        = 150;

  typedef struct packed {
    logic [1:0]       func;
    logic             buffer_ok;
    logic [SMP_W-1:0] current_sample;
    logic [SMP_W-1:0] voltage_sample;
    logic             cv_pin;
  } adc_event_t;

  typedef struct packed {
    logic [1:0]       error_code;
    logic             cv_mode;
    logic             result_new;
    logic [SMP_W-1:0] avg_voltage_counts;
    logic [SMP_W-1:0] avg_current_counts;
    logic [RES_W-1:0] voltage_mv;
    logic [RES_W-1:0] current_tenth_ma;
  } scaler_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  abs_in_if  adc_events ();
  abs_out_if scaled_results ();

  adc_block_average_scaler #(
    .AVG_COUNT(AVG_COUNT_DEF),
    .ADC_BITS (ADC_BITS_DEF)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (adc_events),
    .out_ch   (scaled_results),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predictor state. It starts out as the block does after reset, and the
  // scaling settings are only changed by program_scaling below.
  logic [VFS_W-1:0]  vfs_setting    = VFS_RESET;
  logic [OFF_W-1:0]  off_setting    = OFF_RESET;
  logic [CFS_W-1:0]  cfs_setting    = CFS_RESET;
  logic [SUM_W-1:0]  acc_current    = '0;
  logic [SUM_W-1:0]  acc_voltage    = '0;
  logic [LEFT_W-1:0] events_to_go   = '0;
  logic [1:0]        err_state      = ERR_NONE;
  logic              cv_state       = 1'b0;
  logic [SMP_W-1:0]  avg_v_held     = '0;
  logic [SMP_W-1:0]  avg_c_held     = '0;
  logic [RES_W-1:0]  mv_held        = '0;
  logic [RES_W-1:0]  tenth_ma_held  = '0;
  int unsigned       publish_count  = 0;

  // One expected result per accepted event, oldest first.
  scaler_result_t expected_results[$];
  int unsigned    mismatch_count = 0;

  // Shared between the test tasks and the receiver process.
  bit idle_enable  = 1'b1;
  bit hold_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned saturate_16(longint unsigned value);
    return (value > 65535) ? 65535 : value;
  endfunction

  // Advances the predictor by one event and returns the result that the
  // block must send for it. Every event produces exactly one result; only a
  // good list-0 event with the countdown at zero publishes new averages.
  function automatic scaler_result_t predict_event(adc_event_t ev);
    scaler_result_t  res;
    longint unsigned avg_c;
    longint unsigned avg_v;
    longint unsigned mv;
    longint unsigned off_q8;
    longint unsigned cur_q8;
    longint unsigned cur;
    res.result_new = 1'b0;
    if (ev.func == FUNC_LIST0) begin
      if (ev.buffer_ok) begin
        err_state = ERR_NONE;
        if (events_to_go != 0) begin
          // Accumulate; the sums wrap at their own width.
          events_to_go = events_to_go - 1'b1;
          acc_current  = acc_current + SUM_W'(ev.current_sample);
          acc_voltage  = acc_voltage + SUM_W'(ev.voltage_sample);
        end else begin
          // Publish. This event's own samples are dropped.
          avg_c  = (acc_current / AVG_COUNT_DEF) & SMP_MASK;
          avg_v  = (acc_voltage / AVG_COUNT_DEF) & SMP_MASK;
          mv     = saturate_16(avg_v * vfs_setting / FULL_SCALE);
          // The offset carries 8 fractional bits and uses the truncated voltage.
          off_q8 = longint'(off_setting) * 256 + mv * 256 / MV_PER_COUNT_Q;
          cur_q8 = avg_c * 256;
          cur    = 0;
          if (cur_q8 > off_q8)
            cur = saturate_16((cur_q8 - off_q8) * cfs_setting * 10 / (FULL_SCALE * 256));
          acc_current    = '0;
          acc_voltage    = '0;
          events_to_go   = LEFT_W'(AVG_COUNT_DEF);
          avg_c_held     = SMP_W'(avg_c);
          avg_v_held     = SMP_W'(avg_v);
          mv_held        = RES_W'(mv);
          tenth_ma_held  = RES_W'(cur);
          res.result_new = 1'b1;
          publish_count++;
        end
      end else begin
        err_state = ERR_BUF;
      end
    end else if (ev.func != FUNC_LIST1) begin
      err_state = ERR_SRC;
    end
    // A low CV pin means the supply is in voltage control.
    cv_state = ~ev.cv_pin;
    res.error_code         = err_state;
    res.cv_mode            = cv_state;
    res.avg_voltage_counts = avg_v_held;
    res.avg_current_counts = avg_c_held;
    res.voltage_mv         = mv_held;
    res.current_tenth_ma   = tenth_ma_held;
    return res;
  endfunction

  // Random sample around a center, with some uniform values and some at the
  // ends of the range mixed in. With fixed_samples set it is the center itself,
  // which lets a whole block average to an exact value.
  function automatic logic [SMP_W-1:0] pick_sample(int center, bit fixed_samples);
    int          value;
    int unsigned mode;
    if (fixed_samples)
      return SMP_W'(center);
    mode = $urandom_range(0, 19);
    if (mode < 12) begin
      value = center + int'($urandom_range(0, 126)) - 63;
      if (value < 0)
        value = 0;
      if (value > 4095)
        value = 4095;
    end else if (mode < 17) begin
      value = int'($urandom_range(0, 4095));
    end else begin
      value = mode[0] ? 4095 : 0;
    end
    return SMP_W'(value);
  endfunction

  // Most events are good list-0 events so that the countdown keeps running and
  // blocks get published; the rest are list-1, buffer failures and unknown sources.
  function automatic adc_event_t make_event(int center_c, int center_v, bit fixed_samples);
    adc_event_t  ev;
    int unsigned kind;
    kind            = $urandom_range(0, 99);
    ev.func         = FUNC_LIST0;
    ev.buffer_ok    = 1'b1;
    if (kind >= 96) begin
      ev.func      = 2'($urandom_range(0, 3));
      ev.buffer_ok = 1'($urandom_range(0, 1));
    end else if (kind >= 91) begin
      ev.func      = $urandom_range(0, 1) ? FUNC_UNKNOWN : FUNC_SPARE;
      ev.buffer_ok = 1'($urandom_range(0, 1));
    end else if (kind >= 86) begin
      ev.buffer_ok = 1'b0;
    end else if (kind >= 80) begin
      ev.func      = FUNC_LIST1;
      ev.buffer_ok = 1'($urandom_range(0, 1));
    end
    ev.current_sample = pick_sample(center_c, fixed_samples);
    ev.voltage_sample = pick_sample(center_v, fixed_samples);
    ev.cv_pin         = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  // Offers one event and returns at the edge where it was transferred. Valid
  // is left high so that a following event goes out back to back; any wait that
  // is not a transfer lowers it first.
  task automatic send_event(adc_event_t ev);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      adc_events.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    adc_events.valid          <= 1'b1;
    adc_events.func           <= ev.func;
    adc_events.buffer_ok      <= ev.buffer_ok;
    adc_events.current_sample <= ev.current_sample;
    adc_events.voltage_sample <= ev.voltage_sample;
    adc_events.cv_pin         <= ev.cv_pin;
    @(posedge clk);
    while (!adc_events.ready) @(posedge clk);
    expected_results.push_back(predict_event(ev));
  endtask

  // Stops offering events and waits until every expected result has come
  // back. It always lets at least one edge pass, so the next task never drives
  // valid in the same time step as this one.
  task automatic wait_for_results();
    adc_events.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Writes all three scaling registers on consecutive edges. Only called while
  // the block is idle, since every event has a result and all have arrived.
  task automatic program_scaling(logic [VFS_W-1:0] vfs, logic [OFF_W-1:0] off,
                                 logic [CFS_W-1:0] cfs);
    cfg_we    <= 1'b1;
    cfg_index <= REG_VOLT_FS;
    cfg_data  <= CFG_DAT_W'(vfs);
    @(posedge clk);
    cfg_index <= REG_CUR_OFF;
    cfg_data  <= CFG_DAT_W'(off);
    @(posedge clk);
    cfg_index <= REG_CUR_FS;
    cfg_data  <= CFG_DAT_W'(cfs);
    @(posedge clk);
    cfg_we      <= 1'b0;
    vfs_setting  = vfs;
    off_setting  = off;
    cfs_setting  = cfs;
  endtask

  // Right after reset the countdown is zero, so the very first good list-0
  // event publishes the averages of empty sums, which are all zero.
  task automatic test_reset_publish();
    send_event('{func: FUNC_LIST0, buffer_ok: 1'b1, current_sample: 12'hFFF,
                 voltage_sample: 12'hFFF, cv_pin: 1'b0});
    wait_for_results();
  endtask

  // Every interrupt source, the buffer failure, both CV pin levels and the
  // ends of both sample ranges, with error codes set and cleared again.
  task automatic test_event_sources();
    adc_event_t ev_list[$];
    ev_list = '{
      '{FUNC_LIST1,   1'b1, 12'h000, 12'h000, 1'b1},
      '{FUNC_UNKNOWN, 1'b1, 12'hFFF, 12'hFFF, 1'b0},
      '{FUNC_LIST1,   1'b0, 12'hFFF, 12'h000, 1'b1},
      '{FUNC_LIST0,   1'b1, 12'h000, 12'h000, 1'b1},
      '{FUNC_SPARE,   1'b0, 12'h000, 12'hFFF, 1'b0},
      '{FUNC_LIST0,   1'b0, 12'hFFF, 12'hFFF, 1'b1},
      '{FUNC_LIST0,   1'b1, 12'hFFF, 12'hFFF, 1'b0},
      '{FUNC_LIST1,   1'b1, 12'hAAA, 12'h555, 1'b0},
      '{FUNC_LIST0,   1'b1, 12'hFFF, 12'h000, 1'b1},
      '{FUNC_LIST0,   1'b0, 12'h555, 12'hAAA, 1'b0},
      '{FUNC_LIST0,   1'b1, 12'h000, 12'hFFF, 1'b0},
      '{FUNC_UNKNOWN, 1'b0, 12'h555, 12'hAAA, 1'b1},
      '{FUNC_LIST0,   1'b1, 12'h555, 12'hAAA, 1'b1}
    };
    foreach (ev_list[i])
      send_event(ev_list[i]);
    wait_for_results();
  endtask

  // The sender stops in the middle of the stream until all outstanding
  // results have been transferred, then carries on.
  task automatic test_sender_pause();
    repeat (10) send_event(make_event(2048, 2048, 1'b0));
    wait_for_results();
    repeat (10) send_event(make_event(2048, 2048, 1'b0));
    wait_for_results();
  endtask

  // One setting of the scaling registers followed by random events until
  // enough events have gone out and the wanted number of blocks was published.
  task automatic run_phase(logic [VFS_W-1:0] vfs, logic [OFF_W-1:0] off,
                           logic [CFS_W-1:0] cfs, int center_c, int center_v,
                           bit fixed_samples, int unsigned min_publishes);
    int unsigned sent;
    int unsigned pubs_at_start;
    program_scaling(vfs, off, cfs);
    sent          = 0;
    pubs_at_start = publish_count;
    while (sent < PHASE_ITEMS || publish_count - pubs_at_start < min_publishes) begin
      send_event(make_event(center_c, center_v, fixed_samples));
      sent++;
    end
    wait_for_results();
  endtask

  // Several settings, the extremes among them. The phases with fixed samples
  // run for two publications so that one block lies entirely inside the phase.
  // Full-scale averages with the largest settings drive the voltage to its
  // top; a phase with a low current under a high voltage aims at the current clamp.
  task automatic test_scaling_settings();
    run_phase(VFS_RESET, OFF_RESET, CFS_RESET,
              int'($urandom_range(0, 4095)), int'($urandom_range(0, 4095)), 1'b0, 1);
    run_phase(16'hFFFF, 8'h00, 12'hFFF, 4095, 4095, 1'b1, 2);
    run_phase(16'h0000, 8'hFF, 12'h000,
              int'($urandom_range(0, 4095)), int'($urandom_range(0, 4095)), 1'b0, 1);
    run_phase(16'hFFFF, 8'hFF, 12'hFFF, 4095, 0, 1'b1, 2);
    run_phase(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
              12'($urandom_range(0, 4095)), 200, 4000, 1'b0, 1);
    run_phase(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
              12'($urandom_range(0, 4095)),
              int'($urandom_range(0, 4095)), int'($urandom_range(0, 4095)), 1'b0, 1);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // events without gaps, so the block fills up and stops taking events.
  task automatic test_result_backpressure();
    idle_enable  = 1'b0;
    hold_request = 1'b1;
    repeat (24) send_event(make_event(3000, 1000, 1'b0));
    wait_for_results();
    idle_enable = 1'b1;
  endtask

  // The last part of the run streams events with neither side idling.
  task automatic test_steady_stream();
    int unsigned pubs_at_start;
    int unsigned sent;
    idle_enable   = 1'b0;
    pubs_at_start = publish_count;
    sent          = 0;
    while (sent < PHASE_ITEMS || publish_count == pubs_at_start) begin
      send_event(make_event(int'($urandom_range(0, 4095)),
                            int'($urandom_range(0, 4095)), 1'b0));
      sent++;
    end
    wait_for_results();
  endtask

  // Result receiver. Ready drops in random bursts while idling is enabled, and
  // once for a long hold-off when a test asks for it; the length of that
  // hold-off is counted here, in the receiver's own process.
  initial begin : result_sink
    int unsigned hold;
    scaled_results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        scaled_results.ready <= 1'b0;
        for (hold = 1; hold < RESULT_HOLD_CYCLES; hold++)
          @(posedge clk);
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        scaled_results.ready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(posedge clk);
      end else begin
        scaled_results.ready <= 1'b1;
      end
    end
  end

  // Every result transfer is compared field by field with the oldest
  // expectation. Signals are read right after the edge, so they still hold the
  // values that the block saw at that edge.
  always @(posedge clk) begin : result_check
    scaler_result_t got;
    scaler_result_t want;
    if (rst_n && scaled_results.valid && scaled_results.ready) begin
      got.error_code         = scaled_results.error_code;
      got.cv_mode            = scaled_results.cv_mode;
      got.result_new         = scaled_results.result_new;
      got.avg_voltage_counts = scaled_results.avg_voltage_counts;
      got.avg_current_counts = scaled_results.avg_current_counts;
      got.voltage_mv         = scaled_results.voltage_mv;
      got.current_tenth_ma   = scaled_results.current_tenth_ma;
      if (expected_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: err=%0d cv=%0d new=%0d avg_v=%0d avg_c=%0d mv=%0d cur=%0d",
                   got.error_code, got.cv_mode, got.result_new, got.avg_voltage_counts,
                   got.avg_current_counts, got.voltage_mv, got.current_tenth_ma);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.error_code != want.error_code || got.cv_mode != want.cv_mode ||
            got.result_new != want.result_new ||
            got.avg_voltage_counts != want.avg_voltage_counts ||
            got.avg_current_counts != want.avg_current_counts ||
            got.voltage_mv != want.voltage_mv ||
            got.current_tenth_ma != want.current_tenth_ma) begin
          if (mismatch_count < 10) begin
            $display("result mismatch: expected err=%0d cv=%0d new=%0d avg_v=%0d avg_c=%0d",
                     want.error_code, want.cv_mode, want.result_new,
                     want.avg_voltage_counts, want.avg_current_counts);
            $display("  expected mv=%0d cur=%0d, got err=%0d cv=%0d new=%0d avg_v=%0d",
                     want.voltage_mv, want.current_tenth_ma, got.error_code, got.cv_mode,
                     got.result_new, got.avg_voltage_counts);
            $display("  got avg_c=%0d mv=%0d cur=%0d",
                     got.avg_current_counts, got.voltage_mv, got.current_tenth_ma);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel completes a transfer for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((adc_events.valid && adc_events.ready) ||
          (scaled_results.valid && scaled_results.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("adc_block_average_scaler_test failed");
    $finish;
  end

  // Main sequence. All inputs are known from time zero and reset is held
  // once before the tests run in turn.
  initial begin
    rst_n                     <= 1'b0;
    cfg_we                    <= 1'b0;
    cfg_index                 <= REG_VOLT_FS;
    cfg_data                  <= '0;
    adc_events.valid          <= 1'b0;
    adc_events.func           <= FUNC_LIST0;
    adc_events.buffer_ok      <= 1'b0;
    adc_events.current_sample <= '0;
    adc_events.voltage_sample <= '0;
    adc_events.cv_pin         <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_publish();
    test_event_sources();
    test_sender_pause();
    test_scaling_settings();
    test_result_backpressure();
    test_steady_stream();

    // Give a stray result time to show up after the last expected one.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("adc_block_average_scaler_test passed");
    else
      $display("adc_block_average_scaler_test failed");
    $finish;
  end

endmodule

[adc_block_average_scaler.f]
rtl/core/abs_pkg.sv
rtl/core/abs_if.sv
rtl/core/abs_div.sv
rtl/core/abs_mul.sv
rtl/core/adc_block_average_scaler.sv
rtl/core/abs_chk.sv
bench/adc_block_average_scaler_test.sv
